[src/ecdd_pkg.sv]
// Package for the escaped command/data demultiplexer.
// Holds the protocol bytes, result kind codes, the parse descriptor and the payload table.
// No dependencies.
`default_nettype none

package ecdd_pkg;

	// Default store depths.
	localparam int DATA_DEPTH_DEF = 2048;
	localparam int CMD_DEPTH_DEF  = 128;

	// Protocol bytes.
	localparam logic [7:0] ESC_BYTE      = 8'h5a;
	localparam logic [7:0] TOK_UNESC     = 8'ha5;
	localparam logic [7:0] TOK_RESET     = 8'h01;
	localparam logic [7:0] TOK_XMIT      = 8'h07;
	localparam logic [7:0] TOK_FIRST_LEN = 8'h02;
	localparam logic [7:0] TOK_LAST_LEN  = 8'h06;

	// Result kinds.
	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_CMD   = 2'd1;
	localparam logic [1:0] KIND_RESET = 2'd2;
	localparam logic [1:0] KIND_ERROR = 2'd3;

	// What the parser makes of one byte: kind and byte of the first result,
	// how many results follow from it and whether the last one commits.
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] byte_value;
		logic [1:0] count;
		logic       commit;
	} ecdd_desc_t;

	// Payload length that follows each length token.
	function automatic logic [2:0] payload_len(input logic [7:0] tok);
		logic [2:0] len;
		case (tok)
			8'h02:   len = 3'd4;
			8'h03:   len = 3'd1;
			8'h04:   len = 3'd1;
			8'h05:   len = 3'd6;
			default: len = 3'd1;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

[src/ecdd_byte_if.sv]
// Valid/ready channel that carries one received serial byte per beat.
// No dependencies.
`default_nettype none

interface ecdd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

[src/ecdd_res_if.sv]
// Valid/ready channel that carries one demultiplexed result per beat.
// Index widths follow the store depths; defaults come from ecdd_pkg.
`default_nettype none

interface ecdd_res_if
	import ecdd_pkg::*;
#(
	parameter int DATA_DEPTH = DATA_DEPTH_DEF,
	parameter int CMD_DEPTH  = CMD_DEPTH_DEF,
	localparam int DIDX_W    = $clog2(DATA_DEPTH),
	localparam int CIDX_W    = $clog2(CMD_DEPTH)
);
	logic              valid;
	logic              ready;
	logic [1:0]        kind;
	logic [7:0]        byte_value;
	logic [DIDX_W-1:0] data_index;
	logic [CIDX_W-1:0] cmd_index;
	logic              commit;
	logic              last;

	modport source (output valid, output kind, output byte_value, output data_index,
		output cmd_index, output commit, output last, input ready);
	modport sink   (input valid, input kind, input byte_value, input data_index,
		input cmd_index, input commit, input last, output ready);
endinterface

`default_nettype wire

[src/ecdd_parser.sv]
// Escape parser: holds the parse mode, payload count and both write indices,
// and describes the results of one byte. Depends on ecdd_pkg.
`default_nettype none

module ecdd_parser
	import ecdd_pkg::*;
#(
	parameter int DATA_DEPTH = DATA_DEPTH_DEF,
	parameter int CMD_DEPTH  = CMD_DEPTH_DEF,
	localparam int DIDX_W    = $clog2(DATA_DEPTH),
	localparam int CIDX_W    = $clog2(CMD_DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic [7:0]        rx_byte,
	output ecdd_desc_t             desc,
	output logic      [DIDX_W-1:0] data_index,
	output logic      [CIDX_W-1:0] cmd_index
);

	localparam logic [1:0] MODE_IDLE    = 2'd0;
	localparam logic [1:0] MODE_ESC     = 2'd1;
	localparam logic [1:0] MODE_PAYLOAD = 2'd2;
	localparam logic [1:0] MODE_HALT    = 2'd3;

	logic [1:0]        mode_q, mode_d;
	logic [2:0]        left_q, left_d, left_dec;
	logic [DIDX_W-1:0] didx_q, didx_d, didx_inc;
	logic [CIDX_W-1:0] cidx_q, cidx_d;
	logic [CIDX_W:0]   cidx_sum;
	logic [1:0]        cidx_add;
	logic              clear;

	assign data_index = didx_q;
	assign cmd_index  = cidx_q;

	// Index arithmetic: data index wraps on a single step, the command index
	// may move by up to three slots and wraps with one compare and subtract.
	assign didx_inc = (didx_q == DIDX_W'(DATA_DEPTH - 1)) ? '0 : didx_q + 1'b1;
	assign cidx_sum = {1'b0, cidx_q} + (CIDX_W + 1)'(cidx_add);
	assign cidx_d   = (cidx_sum >= (CIDX_W + 1)'(CMD_DEPTH)) ?
		CIDX_W'(cidx_sum - (CIDX_W + 1)'(CMD_DEPTH)) : CIDX_W'(cidx_sum);
	assign left_dec = (left_q != 3'd0) ? left_q - 3'd1 : 3'd0;

	// Decode of one byte against the current parse mode.
	always_comb begin
		mode_d          = mode_q;
		left_d          = left_q;
		didx_d          = didx_q;
		cidx_add        = 2'd0;
		clear           = 1'b0;
		desc.kind       = KIND_DATA;
		desc.byte_value = rx_byte;
		desc.count      = 2'd0;
		desc.commit     = 1'b0;
		case (mode_q)
			MODE_IDLE: begin
				if (rx_byte == ESC_BYTE) begin
					mode_d = MODE_ESC;
				end else begin
					desc.count = 2'd1;
					didx_d     = didx_inc;
				end
			end
			MODE_ESC: begin
				if (rx_byte == TOK_UNESC) begin
					desc.byte_value = ESC_BYTE;
					desc.count      = 2'd1;
					didx_d          = didx_inc;
					mode_d          = MODE_IDLE;
				end else if (rx_byte == TOK_RESET) begin
					desc.kind       = KIND_RESET;
					desc.byte_value = 8'h00;
					desc.count      = 2'd1;
					clear           = 1'b1;
				end else if (rx_byte == TOK_XMIT) begin
					desc.kind   = KIND_CMD;
					desc.count  = 2'd3;
					desc.commit = 1'b1;
					cidx_add    = 2'd3;
					mode_d      = MODE_IDLE;
				end else if (rx_byte inside {[TOK_FIRST_LEN:TOK_LAST_LEN]}) begin
					desc.kind  = KIND_CMD;
					desc.count = 2'd1;
					cidx_add   = 2'd1;
					left_d     = payload_len(rx_byte);
					mode_d     = MODE_PAYLOAD;
				end else begin
					desc.kind  = KIND_ERROR;
					desc.count = 2'd1;
					mode_d     = MODE_HALT;
				end
			end
			MODE_PAYLOAD: begin
				desc.kind  = KIND_CMD;
				desc.count = 2'd1;
				cidx_add   = 2'd1;
				left_d     = left_dec;
				if (left_dec == 3'd0) begin
					desc.commit = 1'b1;
					mode_d      = MODE_IDLE;
				end
			end
			default: begin
				// Halted: the byte is dropped.
			end
		endcase
	end

	// Parse state; a reset request returns every field to its reset value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			left_q <= 3'd0;
			didx_q <= '0;
			cidx_q <= '0;
		end else if (step) begin
			if (clear) begin
				mode_q <= MODE_IDLE;
				left_q <= 3'd0;
				didx_q <= '0;
				cidx_q <= '0;
			end else begin
				mode_q <= mode_d;
				left_q <= left_d;
				didx_q <= didx_d;
				cidx_q <= cidx_d;
			end
		end
	end

endmodule

`default_nettype wire

[src/escaped_command_data_demux_unit.sv]
// Top level of the escaped command/data demultiplexer.
// Depends on ecdd_pkg, ecdd_byte_if, ecdd_res_if and ecdd_parser.
//
// Channel | Modport | Payload per beat
// --------+---------+--------------------------------------------------------------
// rx      | sink    | rx_byte
// res     | source  | kind, byte_value, data_index, cmd_index, commit, last
//
// A byte is registered on acceptance and parsed into the result register once that
// register is free. One byte per cycle is sustained while each byte gives at most
// one result and the result port is ready; the transmit token holds the result
// register for three beats, one per cycle while the result port is ready.
// A stalled result port fills the result and input registers, then drops ready.
// arst_n clears the parse state, both indices and all valid flags.
`default_nettype none

module escaped_command_data_demux_unit
	import ecdd_pkg::*;
#(
	parameter int DATA_DEPTH = DATA_DEPTH_DEF,
	parameter int CMD_DEPTH  = CMD_DEPTH_DEF,
	localparam int DIDX_W    = $clog2(DATA_DEPTH),
	localparam int CIDX_W    = $clog2(CMD_DEPTH)
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	ecdd_byte_if.sink   rx,
	ecdd_res_if.source  res
);

	logic              vld_s1;
	logic [7:0]        byte_s1;
	logic [1:0]        rem_s2;
	logic [1:0]        kind_s2;
	logic [7:0]        byte_s2;
	logic [DIDX_W-1:0] didx_s2;
	logic [CIDX_W-1:0] cidx_s2;
	logic              commit_s2;
	logic              multi_s2;
	logic [15:0]       didx_ext;
	logic              pop;
	logic              out_free;
	logic              step;
	ecdd_desc_t        desc;
	logic [DIDX_W-1:0] p_didx;
	logic [CIDX_W-1:0] p_cidx;

	// Handshake: the result register takes a new set when empty or once its last beat leaves.
	assign pop      = res.valid && res.ready;
	assign out_free = (rem_s2 == 2'd0) || ((rem_s2 == 2'd1) && res.ready);
	assign step     = vld_s1 && out_free;
	assign rx.ready = !vld_s1 || step;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rx.ready) begin
			vld_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	ecdd_parser #(
		.DATA_DEPTH(DATA_DEPTH),
		.CMD_DEPTH (CMD_DEPTH)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.rx_byte   (byte_s1),
		.desc      (desc),
		.data_index(p_didx),
		.cmd_index (p_cidx)
	);

	// Result register: remaining beat count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_s2 <= 2'd0;
		end else if (step) begin
			rem_s2 <= desc.count;
		end else if (pop) begin
			rem_s2 <= rem_s2 - 2'd1;
		end
	end

	// Result register: payload; the command index steps once per beat sent.
	always_ff @(posedge clk) begin
		if (step && (desc.count != 2'd0)) begin
			kind_s2   <= desc.kind;
			byte_s2   <= desc.byte_value;
			didx_s2   <= p_didx;
			cidx_s2   <= p_cidx;
			commit_s2 <= desc.commit;
			multi_s2  <= (desc.count == 2'd3);
		end else if (pop) begin
			cidx_s2 <= (cidx_s2 == CIDX_W'(CMD_DEPTH - 1)) ? '0 : cidx_s2 + 1'b1;
		end
	end

	// Result beat: the transmit record sends the index bytes after the token.
	assign didx_ext       = 16'(didx_s2);
	assign res.valid      = (rem_s2 != 2'd0);
	assign res.kind       = kind_s2;
	assign res.byte_value = (rem_s2 == 2'd2) ? didx_ext[7:0] :
		((rem_s2 == 2'd1) && multi_s2) ? didx_ext[15:8] : byte_s2;
	assign res.data_index = (kind_s2 == KIND_DATA) ? didx_s2 : '0;
	assign res.cmd_index  = (kind_s2 == KIND_CMD) ? cidx_s2 : '0;
	assign res.last       = (rem_s2 == 2'd1);
	assign res.commit     = commit_s2 && (rem_s2 == 2'd1);

`ifndef SYNTHESIS
	// Only command results come in groups, so every other kind is a final beat.
	a_single_noncmd: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && (res.kind != KIND_CMD)) |-> res.last)
		else $error("non-command result not marked last");

	// A commit closes a command group.
	a_commit_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.commit) |-> (res.last && (res.kind == KIND_CMD)))
		else $error("commit outside final command beat");

	// A group that is not finished keeps the result port valid.
	a_group_cont: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.ready && !res.last) |=> res.valid)
		else $error("result group broken off");
`endif

endmodule

`default_nettype wire
